// File: rtl/ipv4sfc_pkg.sv
package ipv4sfc_pkg;

  localparam int MAX_FLOWS       = 1024;
  localparam int MAX_FRAME_BYTES = 65535;

  localparam int FLOW_IDX_W = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int FLOW_CNT_W = $clog2(MAX_FLOWS + 1);
  localparam int LEN_W      = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [LEN_W-1:0] MIN_IPV4_FRAME = LEN_W'(34);
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam int FLAG_SYN_BIT = 1;
  localparam int FLAG_ACK_BIT = 4;

  localparam logic [1:0] OUTCOME_SKIPPED = 2'd0;
  localparam logic [1:0] OUTCOME_COUNTED = 2'd1;
  localparam logic [1:0] OUTCOME_FULL    = 2'd2;

  typedef struct packed {
    logic             counted;
    logic [31:0]      source;
    logic [LEN_W-1:0] len;
    logic             syn;
  } frame_job_t;

endpackage

// File: rtl/ipv4sfc_front.sv
module ipv4sfc_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [7:0]              frame_byte,
  input  logic                    frame_last,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    job_ready,
  output logic                    job_push,
  output ipv4sfc_pkg::frame_job_t job
);

  logic [15:0] byte_offset;
  logic [15:0] ether_type, ether_type_next;
  logic [3:0]  header_words, header_words_next;
  logic [7:0]  ip_protocol, ip_protocol_next;
  logic [31:0] captured_source, captured_source_next;
  logic [7:0]  tcp_flag_bits, tcp_flag_bits_next;
  logic [15:0] len;
  logic [16:0] tcp_end;
  logic        take;

  assign in_ready = job_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    ether_type_next      = ether_type;
    header_words_next    = header_words;
    ip_protocol_next     = ip_protocol;
    captured_source_next = captured_source;
    tcp_flag_bits_next   = tcp_flag_bits;
    len                  = 16'(ipv4sfc_pkg::MAX_FRAME_BYTES);
    if (byte_offset < 16'(ipv4sfc_pkg::MAX_FRAME_BYTES)) begin
      len = byte_offset + 16'd1;
      if (byte_offset == 16'd12) ether_type_next[15:8] = frame_byte;
      if (byte_offset == 16'd13) ether_type_next[7:0] = frame_byte;
      if (byte_offset == 16'd14) header_words_next = frame_byte[3:0];
      if (byte_offset == 16'd23) ip_protocol_next = frame_byte;
      if (byte_offset >= 16'd26 && byte_offset <= 16'd29)
        captured_source_next = {captured_source[23:0], frame_byte};
      if (byte_offset > 16'd14 && byte_offset == 16'd27 + {10'd0, header_words, 2'b00})
        tcp_flag_bits_next = frame_byte;
    end
  end

  assign tcp_end = 17'd34 + {11'd0, header_words_next, 2'b00};

  always_comb begin
    job.counted = (len >= ipv4sfc_pkg::MIN_IPV4_FRAME) &&
                  (ether_type_next == ipv4sfc_pkg::ETHERTYPE_IPV4);
    job.source  = captured_source_next;
    job.len     = len;
    job.syn     = (ip_protocol_next == ipv4sfc_pkg::PROTO_TCP) &&
                  (tcp_end <= {1'b0, len}) &&
                  tcp_flag_bits_next[ipv4sfc_pkg::FLAG_SYN_BIT] &&
                  !tcp_flag_bits_next[ipv4sfc_pkg::FLAG_ACK_BIT];
  end

  assign job_push = take && frame_last;

  always_ff @(posedge clk) begin
    if (rst || job_push) begin
      byte_offset     <= '0;
      ether_type      <= '0;
      header_words    <= '0;
      ip_protocol     <= '0;
      captured_source <= '0;
      tcp_flag_bits   <= '0;
    end else if (take) begin
      byte_offset     <= len;
      ether_type      <= ether_type_next;
      header_words    <= header_words_next;
      ip_protocol     <= ip_protocol_next;
      captured_source <= captured_source_next;
      tcp_flag_bits   <= tcp_flag_bits_next;
    end
  end

endmodule

// File: rtl/ipv4sfc_queue.sv
module ipv4sfc_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ipv4sfc_pkg::frame_job_t push_job,
  output logic                    not_full,
  input  logic                    pop,
  output logic                    not_empty,
  output ipv4sfc_pkg::frame_job_t pop_job
);

  ipv4sfc_pkg::frame_job_t slots [ipv4sfc_pkg::QUEUE_DEPTH];
  logic [ipv4sfc_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [ipv4sfc_pkg::QUEUE_PTR_W:0]   fill;

  assign not_full  = fill != (ipv4sfc_pkg::QUEUE_PTR_W+1)'(ipv4sfc_pkg::QUEUE_DEPTH);
  assign not_empty = fill != '0;
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule

// File: rtl/ipv4sfc_back.sv
module ipv4sfc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    job_valid,
  input  ipv4sfc_pkg::frame_job_t job,
  output logic                    job_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              outcome,
  output logic [31:0]             source_address,
  output logic                    syn_seen,
  output logic [63:0]             flow_packets,
  output logic [63:0]             flow_bytes,
  output logic [63:0]             flow_syns
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_KEY_RD = 6'b000010,
    S_KEY_CMP= 6'b000100,
    S_CNT_RD = 6'b001000,
    S_UPDATE = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  localparam int IW = ipv4sfc_pkg::FLOW_IDX_W;
  localparam int CW = ipv4sfc_pkg::FLOW_CNT_W;

  state_t state;
  ipv4sfc_pkg::frame_job_t cur;
  logic [CW-1:0]  flows_used;
  logic [CW-1:0]  scan_idx;
  logic [IW-1:0]  hit_idx;
  logic           fresh;
  logic [31:0]    key_mem [ipv4sfc_pkg::MAX_FLOWS];
  logic [191:0]   cnt_mem [ipv4sfc_pkg::MAX_FLOWS];
  logic [31:0]    key_q;
  logic [191:0]   cnt_q;
  logic [63:0]    pkt_next, byt_next, syn_next;
  logic [CW-1:0]  scan_idx_next;

  assign job_pop   = (state == S_IDLE) && job_valid;
  assign out_valid = (state == S_OUT);
  assign scan_idx_next = scan_idx + 1'b1;

  always_comb begin
    if (fresh) begin
      pkt_next = 64'd1;
      byt_next = {48'd0, cur.len};
      syn_next = {63'd0, cur.syn};
    end else begin
      pkt_next = cnt_q[191:128] + 64'd1;
      byt_next = cnt_q[127:64] + {48'd0, cur.len};
      syn_next = cnt_q[63:0] + {63'd0, cur.syn};
    end
  end

  always_ff @(posedge clk) begin
    key_q <= key_mem[scan_idx[IW-1:0]];
    cnt_q <= cnt_mem[hit_idx];
    if (state == S_UPDATE) cnt_mem[hit_idx] <= {pkt_next, byt_next, syn_next};
    if (state == S_KEY_CMP && key_q != cur.source && scan_idx_next == flows_used &&
        flows_used != CW'(ipv4sfc_pkg::MAX_FLOWS))
      key_mem[flows_used[IW-1:0]] <= cur.source;
    if (state == S_IDLE && job_valid && job.counted && flows_used == '0)
      key_mem[0] <= job.source;
  end

  always_ff @(posedge clk) begin
    if (job_pop) cur <= job;
    if (state == S_UPDATE) begin
      outcome        <= ipv4sfc_pkg::OUTCOME_COUNTED;
      source_address <= cur.source;
      syn_seen       <= cur.syn;
      flow_packets   <= pkt_next;
      flow_bytes     <= byt_next;
      flow_syns      <= syn_next;
    end else if (job_pop) begin
      outcome        <= job.counted ? ipv4sfc_pkg::OUTCOME_FULL : ipv4sfc_pkg::OUTCOME_SKIPPED;
      source_address <= job.counted ? job.source : 32'd0;
      syn_seen       <= 1'b0;
      flow_packets   <= '0;
      flow_bytes     <= '0;
      flow_syns      <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      flows_used <= '0;
      scan_idx   <= '0;
      hit_idx    <= '0;
      fresh      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          scan_idx <= '0;
          if (job_valid) begin
            if (!job.counted) begin
              state <= S_OUT;
            end else if (flows_used == '0) begin
              hit_idx    <= '0;
              fresh      <= 1'b1;
              flows_used <= CW'(1);
              state      <= S_UPDATE;
            end else begin
              state <= S_KEY_RD;
            end
          end
        end
        S_KEY_RD: state <= S_KEY_CMP;
        S_KEY_CMP: begin
          if (key_q == cur.source) begin
            hit_idx <= scan_idx[IW-1:0];
            fresh   <= 1'b0;
            state   <= S_CNT_RD;
          end else if (scan_idx_next == flows_used) begin
            if (flows_used == CW'(ipv4sfc_pkg::MAX_FLOWS)) begin
              state <= S_OUT;
            end else begin
              hit_idx    <= flows_used[IW-1:0];
              fresh      <= 1'b1;
              flows_used <= flows_used + 1'b1;
              state      <= S_UPDATE;
            end
          end else begin
            scan_idx <= scan_idx_next;
            state    <= S_KEY_RD;
          end
        end
        S_CNT_RD: state <= S_UPDATE;
        S_UPDATE: state <= S_OUT;
        S_OUT: if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    flows_used <= CW'(ipv4sfc_pkg::MAX_FLOWS))
    else $error("flow count beyond table size");
  a_full_only_when_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == ipv4sfc_pkg::OUTCOME_FULL |->
      flows_used == CW'(ipv4sfc_pkg::MAX_FLOWS))
    else $error("table full reported with free entries");
  a_syn_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && syn_seen |-> outcome == ipv4sfc_pkg::OUTCOME_COUNTED)
    else $error("syn flagged on uncounted frame");
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == ipv4sfc_pkg::OUTCOME_SKIPPED |-> source_address == 32'd0)
    else $error("skipped frame carries an address");

endmodule

// File: rtl/ipv4_source_flow_counter_top.sv
// Result path: an uncounted frame goes straight to the output; a counted frame scans the
//   stored keys in turn, then updates the hit entry, inserts a new one, or reports full.
// Throughput: one byte per cycle while the 4-deep frame queue has room; the back end
//   handles one frame at a time, bounded by the linear key scan of the flow memory.
// Reset: synchronous, active high; clears frame parsing, queue, and flow fill count.
module ipv4_source_flow_counter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  outcome,
  output logic [31:0] source_address,
  output logic        syn_seen,
  output logic [63:0] flow_packets,
  output logic [63:0] flow_bytes,
  output logic [63:0] flow_syns
);

  ipv4sfc_pkg::frame_job_t push_job, pop_job;
  logic push, not_full, pop, not_empty;

  ipv4sfc_front u_front (
    .clk(clk), .rst(rst),
    .frame_byte(frame_byte), .frame_last(frame_last),
    .in_valid(in_valid), .in_ready(in_ready),
    .job_ready(not_full), .job_push(push), .job(push_job)
  );

  ipv4sfc_queue u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_job(push_job), .not_full(not_full),
    .pop(pop), .not_empty(not_empty), .pop_job(pop_job)
  );

  ipv4sfc_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(not_empty), .job(pop_job), .job_pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .outcome(outcome), .source_address(source_address), .syn_seen(syn_seen),
    .flow_packets(flow_packets), .flow_bytes(flow_bytes), .flow_syns(flow_syns)
  );

endmodule

// File: tb/ipv4_source_flow_counter_top_tb.sv
module ipv4_source_flow_counter_top_tb;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [1:0]  oc;
    logic [31:0] src;
    logic        syn;
    logic [63:0] pkts;
    logic [63:0] byts;
    logic [63:0] syns;
  } flow_res_t;

  typedef struct {
    logic [15:0] et;
    int          len;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [7:0]  flags;
    logic [7:0]  pad;
    logic [31:0] src;
    bit          typed;
    flow_res_t   res;
  } frame_row_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  frame_byte = 0;
  logic        frame_last = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  outcome;
  logic [31:0] source_address;
  logic        syn_seen;
  logic [63:0] flow_packets;
  logic [63:0] flow_bytes;
  logic [63:0] flow_syns;

  ipv4_source_flow_counter_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .frame_byte(frame_byte), .frame_last(frame_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .outcome(outcome), .source_address(source_address), .syn_seen(syn_seen),
    .flow_packets(flow_packets), .flow_bytes(flow_bytes), .flow_syns(flow_syns)
  );

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // flow table predictor
  int          cur_off, cur_ihl;
  logic [15:0] cur_et;
  logic [7:0]  cur_proto, cur_flags;
  logic [31:0] cur_src;
  int          flow_idx[bit [31:0]];
  logic [63:0] pkt_cnt[ipv4sfc_pkg::MAX_FLOWS];
  logic [63:0] byte_cnt[ipv4sfc_pkg::MAX_FLOWS];
  logic [63:0] syn_cnt[ipv4sfc_pkg::MAX_FLOWS];
  int          flows_in_use;

  flow_res_t   pending_res[$];
  bit          typed_q[$];
  flow_res_t   typed_res_q[$];
  bit          quiet = 0;
  bit          failed = 0;
  int          results_seen = 0;
  int          bytes_sent = 0;
  longint      cycles = 0;

  task automatic predict_byte(input logic [7:0] b, input logic l);
    int len;
    int idx;
    bit syn;
    flow_res_t r;
    bit t;
    flow_res_t tr;
    if (cur_off < ipv4sfc_pkg::MAX_FRAME_BYTES) begin
      if (cur_off == 12) cur_et[15:8] = b;
      if (cur_off == 13) cur_et[7:0] = b;
      if (cur_off == 14) cur_ihl = b[3:0];
      if (cur_off == 23) cur_proto = b;
      if (cur_off >= 26 && cur_off <= 29) cur_src = {cur_src[23:0], b};
      if (cur_off > 14 && cur_off == 27 + 4 * cur_ihl) cur_flags = b;
      len = cur_off + 1;
    end else begin
      len = ipv4sfc_pkg::MAX_FRAME_BYTES;
    end
    if (!l) begin
      cur_off = len;
      return;
    end
    r = '{ipv4sfc_pkg::OUTCOME_SKIPPED, 0, 0, 0, 0, 0};
    if (len >= 34 && cur_et == ipv4sfc_pkg::ETHERTYPE_IPV4) begin
      r.src = cur_src;
      if (flow_idx.exists(cur_src)) idx = flow_idx[cur_src];
      else if (flows_in_use >= ipv4sfc_pkg::MAX_FLOWS) idx = -1;
      else begin
        idx = flows_in_use;
        flow_idx[cur_src] = idx;
        pkt_cnt[idx] = 0;
        byte_cnt[idx] = 0;
        syn_cnt[idx] = 0;
        flows_in_use++;
      end
      if (idx < 0) r.oc = ipv4sfc_pkg::OUTCOME_FULL;
      else begin
        syn = cur_proto == ipv4sfc_pkg::PROTO_TCP && 14 + 4 * cur_ihl + 20 <= len &&
              cur_flags[ipv4sfc_pkg::FLAG_SYN_BIT] && !cur_flags[ipv4sfc_pkg::FLAG_ACK_BIT];
        pkt_cnt[idx] += 1;
        byte_cnt[idx] += 64'(len);
        if (syn) syn_cnt[idx] += 1;
        r = '{ipv4sfc_pkg::OUTCOME_COUNTED, cur_src, syn, pkt_cnt[idx], byte_cnt[idx],
              syn_cnt[idx]};
      end
    end
    t = typed_q.pop_front();
    tr = typed_res_q.pop_front();
    pending_res.push_back(t ? tr : r);
    cur_off = 0; cur_et = 0; cur_ihl = 0; cur_proto = 0; cur_src = 0; cur_flags = 0;
  endtask

  task automatic check_result();
    flow_res_t e;
    if (pending_res.size() == 0) begin
      $error("unexpected transfer: outcome %0d source %h", outcome, source_address);
      failed = 1;
      return;
    end
    e = pending_res.pop_front();
    results_seen++;
    if (outcome !== e.oc) begin
      $error("outcome exp %0d got %0d", e.oc, outcome); failed = 1;
    end
    if (source_address !== e.src) begin
      $error("source_address exp %h got %h", e.src, source_address); failed = 1;
    end
    if (syn_seen !== e.syn) begin
      $error("syn_seen exp %0d got %0d", e.syn, syn_seen); failed = 1;
    end
    if (flow_packets !== e.pkts) begin
      $error("flow_packets exp %0d got %0d", e.pkts, flow_packets); failed = 1;
    end
    if (flow_bytes !== e.byts) begin
      $error("flow_bytes exp %0d got %0d", e.byts, flow_bytes); failed = 1;
    end
    if (flow_syns !== e.syns) begin
      $error("flow_syns exp %0d got %0d", e.syns, flow_syns); failed = 1;
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd6000000) begin
      $display("FAILURE");
      $finish;
    end
    if (!rst) begin
      if (in_valid && in_ready) predict_byte(frame_byte, frame_last);
      if (out_valid && out_ready) check_result();
      out_ready <= quiet || ($urandom_range(99) >= 21);
    end
  end

  function automatic byte_q_t build_frame(frame_row_t r);
    byte_q_t f;
    int fp;
    for (int i = 0; i < r.len; i++) f.push_back(r.pad);
    fp = 27 + 4 * r.ihl;
    if (fp < r.len) f[fp] = r.flags;
    if (r.len > 12) f[12] = r.et[15:8];
    if (r.len > 13) f[13] = r.et[7:0];
    if (r.len > 14) f[14] = {4'h4, r.ihl};
    if (r.len > 23) f[23] = r.proto;
    for (int i = 0; i < 4; i++) if (26 + i < r.len) f[26 + i] = r.src[31 - 8 * i -: 8];
    return f;
  endfunction

  task automatic send_frame(byte_q_t f, input bit typed, input flow_res_t tr);
    typed_q.push_back(typed);
    typed_res_q.push_back(tr);
    for (int i = 0; i < f.size(); i++) begin
      while (!quiet && $urandom_range(99) < 21) begin
        in_valid <= 0;
        @(posedge clk);
      end
      in_valid <= 1;
      frame_byte <= f[i];
      frame_last <= (i == f.size() - 1);
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      bytes_sent++;
    end
  endtask

  function automatic frame_row_t mk_row(logic [15:0] et, int len, logic [3:0] ihl,
                                        logic [7:0] proto, logic [7:0] flags,
                                        logic [7:0] pad, logic [31:0] src, bit typed,
                                        flow_res_t res);
    frame_row_t r;
    r = '{et, len, ihl, proto, flags, pad, src, typed, res};
    return r;
  endfunction

  frame_row_t rows[$];
  flow_res_t  none;
  logic [31:0] src_pool[16];

  initial begin
    frame_row_t r;
    byte_q_t f;
    none = '{ipv4sfc_pkg::OUTCOME_SKIPPED, 0, 0, 0, 0, 0};
    cur_off = 0; cur_et = 0; cur_ihl = 0; cur_proto = 0; cur_src = 0; cur_flags = 0;
    flows_in_use = 0;

    rows.push_back(mk_row(16'h0800, 60, 5, 6, 8'h02, 8'h00, 32'h0A000001, 1,
                          '{ipv4sfc_pkg::OUTCOME_COUNTED, 32'h0A000001, 1, 1, 60, 1}));
    rows.push_back(mk_row(16'h0800, 64, 5, 6, 8'h12, 8'h5A, 32'h0A000001, 0, none));
    rows.push_back(mk_row(16'h0806, 60, 5, 6, 8'h02, 8'h00, 32'h0A000001, 1, none));
    rows.push_back(mk_row(16'h0800, 33, 5, 6, 8'h02, 8'h00, 32'h0A000001, 1, none));
    rows.push_back(mk_row(16'h0800, 34, 5, 6, 8'h02, 8'hFF, 32'hFFFFFFFF, 1,
                          '{ipv4sfc_pkg::OUTCOME_COUNTED, 32'hFFFFFFFF, 0, 1, 34, 0}));
    rows.push_back(mk_row(16'h0800, 54, 5, 6, 8'h02, 8'h00, 32'h00000000, 1,
                          '{ipv4sfc_pkg::OUTCOME_COUNTED, 32'h00000000, 1, 1, 54, 1}));
    rows.push_back(mk_row(16'h0800, 40, 0, 6, 8'h02, 8'h00, 32'h0A000001, 0, none));
    rows.push_back(mk_row(16'h0800, 100, 15, 6, 8'h02, 8'hA5, 32'h0A000001, 0, none));
    rows.push_back(mk_row(16'h0800, 93, 15, 6, 8'h02, 8'h00, 32'h0A000001, 0, none));
    rows.push_back(mk_row(16'h0800, 60, 5, 17, 8'h02, 8'h00, 32'h0A000001, 0, none));
    rows.push_back(mk_row(16'h0800, 60, 5, 6, 8'hFF, 8'h00, 32'h0A000001, 0, none));
    rows.push_back(mk_row(16'h0800, 60, 1, 6, 8'h02, 8'h00, 32'hFFFFFFFF, 0, none));
    rows.push_back(mk_row(16'h0800, 1, 5, 6, 8'h02, 8'h00, 32'h0A000001, 1, none));
    rows.push_back(mk_row(16'h0008, 60, 5, 6, 8'h02, 8'h00, 32'h0A000001, 1, none));
    rows.push_back(mk_row(16'hFFFF, 60, 5, 6, 8'h02, 8'hFF, 32'h0A000001, 1, none));

    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) send_frame(build_frame(rows[i]), rows[i].typed, rows[i].res);

    for (int i = 0; i < 16; i++) src_pool[i] = $urandom();
    while (bytes_sent < 1550) begin
      quiet = (bytes_sent >= 1000 && bytes_sent < 1300);
      if ($urandom_range(99) < 80) begin
        r.et = ($urandom_range(9) == 0) ? 16'($urandom()) : ipv4sfc_pkg::ETHERTYPE_IPV4;
        r.len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(34, 90);
        r.ihl = ($urandom_range(3) == 0) ? 4'($urandom()) : 4'd5;
        r.proto = ($urandom_range(4) == 0) ? 8'($urandom()) : ipv4sfc_pkg::PROTO_TCP;
        r.flags = ($urandom_range(1) == 0) ? 8'h02 : 8'($urandom());
        r.pad = 8'($urandom());
        r.src = ($urandom_range(9) == 0) ? $urandom() : src_pool[$urandom_range(15)];
        f = build_frame(r);
        for (int i = 0; i < f.size(); i++)
          if ($urandom_range(9) == 0 && (i < 12 || i > 29)) f[i] = 8'($urandom());
      end else begin
        f.delete();
        repeat ($urandom_range(1, 40)) f.push_back(8'($urandom()));
      end
      send_frame(f, 0, none);
    end
    quiet = 0;

    in_valid <= 0;
    while (pending_res.size() != 0 || typed_q.size() != 0) @(posedge clk);
    repeat (2 * ipv4sfc_pkg::MAX_FLOWS + 20) @(posedge clk);
    if (!failed) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ipv4sfc_pkg.sv
rtl/ipv4sfc_front.sv
rtl/ipv4sfc_queue.sv
rtl/ipv4sfc_back.sv
rtl/ipv4_source_flow_counter_top.sv
tb/ipv4_source_flow_counter_top_tb.sv
